// File: hdl/ts_pkg.sv
// shared types, constants and default table builder for the score table
package ts_pkg;

    localparam int TS_MAX_ENTRIES = 64;
    localparam int TS_IDX_W       = 6;
    localparam int TS_OP_W        = 2;
    localparam int TS_SCORE_W     = 32;
    localparam int TS_LEVEL_W     = 16;
    localparam int TS_TAG_W       = 16;
    localparam int TS_FIXED_N     = 5;

    localparam logic [63:0]           TS_SCORE_FACTOR = 64'd953;
    localparam logic [TS_SCORE_W-1:0] TS_SCORE_MAX    = '1;

    localparam logic [TS_SCORE_W-1:0] TS_FIXED_SCORE [TS_FIXED_N] =
        '{32'd10000, 32'd50000, 32'd100000, 32'd200000, 32'd400000};
    localparam logic [TS_LEVEL_W-1:0] TS_FIXED_LEVEL [TS_FIXED_N] =
        '{16'd1, 16'd2, 16'd4, 16'd6, 16'd8};

    typedef enum logic [TS_OP_W-1:0] {
        TS_OP_OFFER   = 2'd0,
        TS_OP_READ    = 2'd1,
        TS_OP_RESTORE = 2'd2
    } ts_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SH_RD,
        ST_SH_CMP,
        ST_WRITE_NEW,
        ST_RESTORE,
        ST_READ,
        ST_DONE
    } ts_state_t;

    typedef struct packed {
        logic [TS_SCORE_W-1:0] score;
        logic [TS_LEVEL_W-1:0] level;
        logic [TS_TAG_W-1:0]   tag;
    } ts_rec_t;

    // default record: fixed ones carry their own tag, formula ones take the restore tag (zero after reset)
    typedef struct packed {
        logic [TS_SCORE_W-1:0] score;
        logic [TS_LEVEL_W-1:0] level;
        logic                  fixed;
        logic [TS_TAG_W-1:0]   fixed_tag;
    } ts_def_rec_t;

    typedef ts_def_rec_t [TS_MAX_ENTRIES-1:0] ts_def_table_t;

    typedef struct packed {
        logic load_item;
        logic scan_rd;
        logic scan_cmp;
        logic p_load_lo;
        logic shift_rd;
        logic shift_wr;
        logic write_new;
        logic restore_wr;
        logic zero_tag;
        logic read_rd;
        logic load_out;
    } ts_cmd_t;

    typedef struct packed {
        logic [TS_OP_W-1:0] op;
        logic               cnt_last;
        logic               p_zero;
        logic               offer_win;
        logic               shift_more;
        logic               idx_ok;
        logic               out_free;
    } ts_sts_t;

    // default table, already in rank order (stable sort by descending score)
    function automatic ts_def_table_t ts_build_defaults(input int entries);
        ts_def_table_t tbl;
        ts_def_rec_t   tmp;
        logic [63:0]   k;
        logic [63:0]   v;
        tbl = '0;
        for (int i = 0; i < TS_MAX_ENTRIES; i++)
        begin
            k = 64'(i);
            v = (k + 64'd1) * (k * k * k + 64'd1) * TS_SCORE_FACTOR;
            tbl[i].score     = (v > 64'(TS_SCORE_MAX)) ? TS_SCORE_MAX : v[TS_SCORE_W-1:0];
            tbl[i].level     = TS_LEVEL_W'(2 * i + 1);
            tbl[i].fixed     = 1'b0;
            tbl[i].fixed_tag = '0;
        end
        for (int i = 0; i < TS_FIXED_N; i++)
        begin
            tbl[i].score     = TS_FIXED_SCORE[i];
            tbl[i].level     = TS_FIXED_LEVEL[i];
            tbl[i].fixed     = 1'b1;
            tbl[i].fixed_tag = TS_TAG_W'(i);
        end
        for (int pass = 0; pass < TS_MAX_ENTRIES; pass++)
        begin
            for (int i = 0; i < TS_MAX_ENTRIES - 1; i++)
            begin
                if ((i + 1 < entries) && (tbl[i].score < tbl[i+1].score))
                begin
                    tmp        = tbl[i];
                    tbl[i]     = tbl[i+1];
                    tbl[i+1]   = tmp;
                end
            end
        end
        return tbl;
    endfunction

endpackage

// File: hdl/ts_if.sv
// item and result channel interfaces of the score table
interface ts_item_if import ts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TS_OP_W-1:0]    operation;
    logic [TS_SCORE_W-1:0] new_score;
    logic [TS_LEVEL_W-1:0] new_level;
    logic [TS_TAG_W-1:0]   new_tag;
    logic [TS_IDX_W-1:0]   read_index;

    modport source (output valid, output operation, output new_score, output new_level,
                    output new_tag, output read_index, input ready);
    modport sink   (input valid, input operation, input new_score, input new_level,
                    input new_tag, input read_index, output ready);
endinterface

interface ts_result_if import ts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [TS_IDX_W-1:0]   rank;
    logic [TS_SCORE_W-1:0] entry_score;
    logic [TS_LEVEL_W-1:0] entry_level;
    logic [TS_TAG_W-1:0]   entry_tag;

    modport source (output valid, output accepted, output rank, output entry_score,
                    output entry_level, output entry_tag, input ready);
    modport sink   (input valid, input accepted, input rank, input entry_score,
                    input entry_level, input entry_tag, output ready);
endinterface

// File: hdl/top_score_table.sv
// top level of the sorted score table: controller plus datapath
// one item at a time; the next item beat can come in the cycle after the result loads; a held
//   result stalls only the next load; after reset the defaults load first, with ready low
module top_score_table import ts_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    ts_item_if.sink         item,
    ts_result_if.source     result
);

    // command and status bundles between sequencer and datapath
    ts_cmd_t cmd;
    ts_sts_t sts;

    // sequencer: owns the item handshake and steps through each operation
    ts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: record memory, scan for the lowest slot, shift walk, result register
    ts_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .item_operation (item.operation),
        .item_score     (item.new_score),
        .item_level     (item.new_level),
        .item_tag       (item.new_tag),
        .item_index     (item.read_index),
        .res_ready      (result.ready),
        .res_valid      (result.valid),
        .res_accepted   (result.accepted),
        .res_rank       (result.rank),
        .res_score      (result.entry_score),
        .res_level      (result.entry_level),
        .res_tag        (result.entry_tag)
    );

endmodule

// File: hdl/ts_datapath.sv
// record memory, walk counters, item and result registers of the score table
module ts_datapath import ts_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ts_cmd_t               cmd,
    output ts_sts_t               sts,
    input  logic [TS_OP_W-1:0]    item_operation,
    input  logic [TS_SCORE_W-1:0] item_score,
    input  logic [TS_LEVEL_W-1:0] item_level,
    input  logic [TS_TAG_W-1:0]   item_tag,
    input  logic [TS_IDX_W-1:0]   item_index,
    input  logic                  res_ready,
    output logic                  res_valid,
    output logic                  res_accepted,
    output logic [TS_IDX_W-1:0]   res_rank,
    output logic [TS_SCORE_W-1:0] res_score,
    output logic [TS_LEVEL_W-1:0] res_level,
    output logic [TS_TAG_W-1:0]   res_tag
);

    localparam int AW = $clog2(ENTRIES);
    localparam ts_def_table_t DEF_TABLE = ts_build_defaults(ENTRIES);

    logic [TS_OP_W-1:0]    op_reg;
    logic [TS_SCORE_W-1:0] score_reg;
    logic [TS_LEVEL_W-1:0] level_reg;
    logic [TS_TAG_W-1:0]   tag_reg;
    logic [TS_IDX_W-1:0]   idx_reg;

    logic [AW-1:0]         cnt_reg;
    logic [AW-1:0]         lo_reg;
    logic [AW-1:0]         p_reg;
    logic [TS_SCORE_W-1:0] min_reg;
    logic                  acc_reg;

    ts_rec_t               mem [ENTRIES];
    ts_rec_t               rdata_reg;

    logic                  out_valid_reg;
    logic                  out_acc_reg;
    logic [TS_IDX_W-1:0]   out_rank_reg;
    ts_rec_t               out_rec_reg;

    logic                  re;
    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    ts_rec_t               wdata;
    ts_def_rec_t           def_rec;
    logic                  read_hit;

    assign def_rec  = DEF_TABLE[TS_IDX_W'(cnt_reg)];
    assign read_hit = (op_reg == TS_OP_READ) && sts.idx_ok;

    always_comb
    begin
        re    = cmd.scan_rd | cmd.shift_rd | cmd.read_rd;
        raddr = cnt_reg;
        if (cmd.shift_rd)
        begin
            raddr = p_reg - 1'b1;
        end
        if (cmd.read_rd)
        begin
            raddr = idx_reg[AW-1:0];
        end

        we    = cmd.restore_wr | cmd.shift_wr | cmd.write_new;
        waddr = p_reg;
        wdata = rdata_reg;
        if (cmd.restore_wr)
        begin
            waddr       = cnt_reg;
            wdata.score = def_rec.score;
            wdata.level = def_rec.level;
            if (def_rec.fixed)
            begin
                wdata.tag = def_rec.fixed_tag;
            end
            else if (cmd.zero_tag)
            begin
                wdata.tag = '0;
            end
            else
            begin
                wdata.tag = tag_reg;
            end
        end
        else if (cmd.write_new)
        begin
            wdata.score = score_reg;
            wdata.level = level_reg;
            wdata.tag   = tag_reg;
        end
    end

    always_comb
    begin
        sts.op         = op_reg;
        sts.cnt_last   = (cnt_reg == AW'(ENTRIES - 1));
        sts.p_zero     = (p_reg == '0);
        sts.offer_win  = (score_reg != '0) && (score_reg > min_reg);
        sts.shift_more = (rdata_reg.score < score_reg);
        sts.idx_ok     = ({1'b0, idx_reg} < (TS_IDX_W + 1)'(ENTRIES));
        sts.out_free   = !out_valid_reg || res_ready;
    end

    // record memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_cmp || cmd.restore_wr)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.load_item)
            begin
                acc_reg <= 1'b0;
            end
            else if (cmd.write_new)
            begin
                acc_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= item_operation;
            score_reg <= item_score;
            level_reg <= item_level;
            tag_reg   <= item_tag;
            idx_reg   <= item_index;
        end

        // first lowest score wins, ties keep the smaller rank
        if (cmd.scan_cmp && ((cnt_reg == '0) || (rdata_reg.score < min_reg)))
        begin
            min_reg <= rdata_reg.score;
            lo_reg  <= cnt_reg;
        end

        if (cmd.p_load_lo)
        begin
            p_reg <= lo_reg;
        end
        else if (cmd.shift_wr)
        begin
            p_reg <= p_reg - 1'b1;
        end

        if (cmd.load_out)
        begin
            out_acc_reg  <= acc_reg;
            out_rank_reg <= acc_reg ? TS_IDX_W'(p_reg) : '0;
            out_rec_reg  <= read_hit ? rdata_reg : '0;
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_accepted = out_acc_reg;
    assign res_rank     = out_rank_reg;
    assign res_score    = out_rec_reg.score;
    assign res_level    = out_rec_reg.level;
    assign res_tag      = out_rec_reg.tag;

    a_new_at_or_above_lo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> (p_reg <= lo_reg))
        else $error("new record placed below the replaced slot");

    a_shift_not_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> (p_reg != '0))
        else $error("record shifted past rank zero");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || res_ready))
        else $error("pending result overwritten");

endmodule

// File: hdl/ts_ctrl.sv
// sequencing state machine of the score table
module ts_ctrl import ts_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  ts_sts_t sts,
    output ts_cmd_t cmd
);

    ts_state_t state_reg;
    ts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.restore_wr = 1'b1;
                cmd.zero_tag   = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    TS_OP_OFFER:   state_next = ST_SCAN_RD;
                    TS_OP_READ:    state_next = sts.idx_ok ? ST_READ : ST_DONE;
                    TS_OP_RESTORE: state_next = ST_RESTORE;
                    default:       state_next = ST_DONE;
                endcase
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                state_next   = sts.cnt_last ? ST_DECIDE : ST_SCAN_RD;
            end
            ST_DECIDE:
            begin
                if (sts.offer_win)
                begin
                    cmd.p_load_lo = 1'b1;
                    state_next    = ST_SH_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SH_RD:
            begin
                if (sts.p_zero)
                begin
                    state_next = ST_WRITE_NEW;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SH_CMP;
                end
            end
            ST_SH_CMP:
            begin
                if (sts.shift_more)
                begin
                    cmd.shift_wr = 1'b1;
                    state_next   = ST_SH_RD;
                end
                else
                begin
                    state_next = ST_WRITE_NEW;
                end
            end
            ST_WRITE_NEW:
            begin
                cmd.write_new = 1'b1;
                state_next    = ST_DONE;
            end
            ST_RESTORE:
            begin
                cmd.restore_wr = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.read_rd = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: bench/score_table_checker.sv
// checker for the score table: mirrors the sorted records and matches every result beat
module score_table_checker import ts_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    ts_item_if          item,
    ts_result_if        result,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    typedef struct packed {
        logic                  accepted;
        logic [TS_IDX_W-1:0]   rank;
        logic [TS_SCORE_W-1:0] score;
        logic [TS_LEVEL_W-1:0] level;
        logic [TS_TAG_W-1:0]   tag;
    } outcome_t;

    logic [TS_SCORE_W-1:0] score_tbl [ENTRIES];
    logic [TS_LEVEL_W-1:0] level_tbl [ENTRIES];
    logic [TS_TAG_W-1:0]   tag_tbl   [ENTRIES];

    outcome_t outcome_q [$];

    function automatic void swap_ranks(input int a, input int b);
        logic [TS_SCORE_W-1:0] s;
        logic [TS_LEVEL_W-1:0] l;
        logic [TS_TAG_W-1:0]   t;
        s = score_tbl[a];
        l = level_tbl[a];
        t = tag_tbl[a];
        score_tbl[a] = score_tbl[b];
        level_tbl[a] = level_tbl[b];
        tag_tbl[a]   = tag_tbl[b];
        score_tbl[b] = s;
        level_tbl[b] = l;
        tag_tbl[b]   = t;
    endfunction

    function automatic void load_default_table(input logic [TS_TAG_W-1:0] fill_tag);
        logic [63:0] k;
        logic [63:0] v;
        for (int i = 0; i < ENTRIES; i++)
        begin
            k = 64'(i);
            v = (k + 64'd1) * (k * k * k + 64'd1) * TS_SCORE_FACTOR;
            score_tbl[i] = (v > 64'(TS_SCORE_MAX)) ? TS_SCORE_MAX : v[TS_SCORE_W-1:0];
            level_tbl[i] = TS_LEVEL_W'(2 * i + 1);
            tag_tbl[i]   = fill_tag;
        end
        for (int i = 0; i < TS_FIXED_N && i < ENTRIES; i++)
        begin
            score_tbl[i] = TS_FIXED_SCORE[i];
            level_tbl[i] = TS_FIXED_LEVEL[i];
            tag_tbl[i]   = TS_TAG_W'(i);
        end
        // adjacent swaps on strict less keep equal scores in slot order
        for (int pass = 0; pass < ENTRIES; pass++)
            for (int i = 0; i + 1 < ENTRIES; i++)
                if (score_tbl[i] < score_tbl[i+1])
                    swap_ranks(i, i + 1);
    endfunction

    function automatic outcome_t apply_item(
        input logic [TS_OP_W-1:0]    op,
        input logic [TS_SCORE_W-1:0] score,
        input logic [TS_LEVEL_W-1:0] level,
        input logic [TS_TAG_W-1:0]   tag,
        input logic [TS_IDX_W-1:0]   idx
    );
        outcome_t res;
        int       low;
        int       pos;
        res = '0;
        case (op)
            TS_OP_OFFER:
            begin
                // first slot holding the smallest score
                low = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (score_tbl[i] < score_tbl[low])
                        low = i;
                if (score != '0 && score > score_tbl[low])
                begin
                    pos = low;
                    score_tbl[pos] = score;
                    level_tbl[pos] = level;
                    tag_tbl[pos]   = tag;
                    while (pos > 0 && score_tbl[pos-1] < score_tbl[pos])
                    begin
                        swap_ranks(pos - 1, pos);
                        pos--;
                    end
                    res.accepted = 1'b1;
                    res.rank     = TS_IDX_W'(pos);
                end
            end
            TS_OP_READ:
            begin
                if (idx < ENTRIES)
                begin
                    res.score = score_tbl[idx];
                    res.level = level_tbl[idx];
                    res.tag   = tag_tbl[idx];
                end
            end
            TS_OP_RESTORE:
                load_default_table(tag);
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        int       bad;
        if (!rst_n)
        begin
            load_default_table('0);
            outcome_q.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            bad = 0;
            // result first so a beat never pairs with an item taken at the same edge
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    bad++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    bad += field_diff("accepted", want.accepted, result.accepted);
                    bad += field_diff("rank", want.rank, result.rank);
                    bad += field_diff("entry_score", want.score, result.entry_score);
                    bad += field_diff("entry_level", want.level, result.entry_level);
                    bad += field_diff("entry_tag", want.tag, result.entry_tag);
                end
            end
            if (item.valid && item.ready)
                outcome_q.push_back(apply_item(item.operation, item.new_score,
                                               item.new_level, item.new_tag,
                                               item.read_index));
            outstanding <= outcome_q.size();
            fail_count  <= fail_count + bad;
        end
    end

endmodule

// File: bench/tb_top.sv
// testbench top for the score table: clock, reset, item and result traffic, verdict
module tb_top;
    import ts_pkg::*;

    localparam int ENTRIES      = 8;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_ITEMS   = 80;

    // code the block has no operation for, must leave the table alone
    localparam logic [TS_OP_W-1:0] OP_SPARE = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // idling knobs, re-picked during the run; calm turns all new idling off
    int   gap_pct   = 25;
    int   stall_pct = 20;
    logic calm      = 1'b0;

    int unsigned fails;
    int unsigned outstanding;

    ts_item_if   item_ch ();
    ts_result_if result_ch ();

    top_score_table #(
        .ENTRIES (ENTRIES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    score_table_checker #(
        .ENTRIES (ENTRIES)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .fail_count  (fails),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // generous ceiling on run time: reaching it reports a fail
    initial
    begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    // one item beat: optional idle burst, then hold valid until the block takes it
    task automatic send_beat(
        input logic [TS_OP_W-1:0]    op,
        input logic [TS_SCORE_W-1:0] score,
        input logic [TS_LEVEL_W-1:0] level,
        input logic [TS_TAG_W-1:0]   tag,
        input logic [TS_IDX_W-1:0]   idx
    );
        int gap;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 18);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= op;
        item_ch.new_score  <= score;
        item_ch.new_level  <= level;
        item_ch.new_tag    <= tag;
        item_ch.read_index <= idx;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // hold off until every result owed has come back
    task automatic drain();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // offered scores: zero, the default table's range, repeated values for ties,
    // full range, the very top and a band around the lowest fixed score
    function automatic logic [TS_SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return TS_SCORE_W'($urandom_range(1, 3000000));
            4, 5:    return TS_SCORE_W'(1000000 * $urandom_range(1, 6));
            6, 7:    return TS_SCORE_W'($urandom());
            8:       return TS_SCORE_MAX - TS_SCORE_W'($urandom_range(0, 3));
            default: return TS_SCORE_W'($urandom_range(9000, 11000));
        endcase
    endfunction

    // result side: ready drops in bursts of random length
    initial
    begin : sink_side
        int stall;
        result_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                stall = $urandom_range(1, 18) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : source_side
        int                  pick;
        logic [TS_OP_W-1:0]  op;
        logic [TS_IDX_W-1:0] idx;

        item_ch.valid      = 1'b0;
        item_ch.operation  = TS_OP_OFFER;
        item_ch.new_score  = '0;
        item_ch.new_level  = '0;
        item_ch.new_tag    = '0;
        item_ch.read_index = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // power-on table, every rank plus reads past the end
        for (int i = 0; i < ENTRIES; i++)
            send_beat(TS_OP_READ, '0, '0, '0, TS_IDX_W'(i));
        send_beat(TS_OP_READ, '0, '0, '0, TS_IDX_W'(ENTRIES));
        send_beat(TS_OP_READ, '0, '0, '0, '1);

        // zero score and a score equal to the lowest are both turned away
        send_beat(TS_OP_OFFER, '0, '1, '1, '1);
        send_beat(TS_OP_OFFER, TS_FIXED_SCORE[0], 16'd7, 16'd7, '0);
        // just above the lowest stays at the bottom
        send_beat(TS_OP_OFFER, TS_FIXED_SCORE[0] + 32'd1, 16'd3, 16'h5a5a, '0);
        // top score climbs to rank 0, a tie with it settles just below
        send_beat(TS_OP_OFFER, TS_SCORE_MAX, '1, '1, '0);
        send_beat(TS_OP_OFFER, TS_SCORE_MAX, 16'd1, 16'd2, '0);
        send_beat(OP_SPARE, '1, '1, '1, '1);

        // let the table settle before looking at it
        item_ch.valid <= 1'b0;
        drain();
        send_beat(TS_OP_READ, '0, '0, '0, 6'd0);
        send_beat(TS_OP_READ, '0, '0, '0, 6'd1);

        // restore with an all-ones tag, check a formula rank and a fixed one
        send_beat(TS_OP_RESTORE, '0, '0, '1, '0);
        send_beat(TS_OP_READ, '0, '0, '0, 6'd0);
        send_beat(TS_OP_READ, '0, '0, '0, TS_IDX_W'(ENTRIES - 1));
        send_beat(TS_OP_RESTORE, '1, '1, '0, '1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // change idling character now and then, including stretches with none
            if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 8;
                    default: stall_pct = 35;
                endcase
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (n == RANDOM_ITEMS / 3 || n == (2 * RANDOM_ITEMS) / 3)
            begin
                item_ch.valid <= 1'b0;
                drain();
            end

            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = TS_OP_OFFER;
            else if (pick < 85)
                op = TS_OP_READ;
            else if (pick < 95)
                op = TS_OP_RESTORE;
            else
                op = OP_SPARE;

            // reads mostly inside the table, some beyond it
            if ($urandom_range(0, 4) == 0)
                idx = TS_IDX_W'($urandom_range(0, 63));
            else
                idx = TS_IDX_W'($urandom_range(0, ENTRIES - 1));

            send_beat(op, pick_score(), TS_LEVEL_W'($urandom()), TS_TAG_W'($urandom()), idx);
        end
        item_ch.valid <= 1'b0;

        drain();
        repeat (2 * ENTRIES + 40) @(posedge clk);

        if (fails == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
